>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/kscc_pkg.sv
// Shared types, register codes and reset values for the keyword confirm block.
// No dependencies; used by all modules of the block.
package kscc_pkg;

  localparam int SCORE_W    = 8;
  localparam int NUM_SCORES = 8;
  localparam int KW_W       = 3;
  localparam int TABLE_W    = 56;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAME_W_DEF = 32;
  localparam int CLASSES_DEF = 8;

  typedef logic [SCORE_W-1:0]                  score_t;
  typedef logic [KW_W-1:0]                     kw_t;
  typedef logic [TABLE_W-1:0]                  table_t;
  typedef logic [NUM_SCORES-1:0][SCORE_W-1:0]  score_vec_t;
  typedef logic [CFG_IDX_W-1:0]                cfg_idx_t;

  // Register indexes
  localparam cfg_idx_t REG_THRESHOLD = 2'd0;
  localparam cfg_idx_t REG_COOLDOWN  = 2'd1;
  localparam cfg_idx_t REG_CONFIRM   = 2'd2;

  localparam table_t THRESHOLD_RST = 56'h62_62_60_60_5E_5E_60;
  localparam table_t COOLDOWN_RST  = 56'h12_12_14_14_10_10_14;
  localparam score_t CONFIRM_RST   = 8'd2;
  localparam score_t HITS_MAX      = 8'hFF;

  // Byte k-1 of a packed per-keyword table; keyword 0 selects the zero pad byte above it.
  function automatic score_t tbl_byte(input table_t tbl, input kw_t kw);
    logic [TABLE_W+SCORE_W-1:0] ext;
    kw_t                        sel;
    ext = {{SCORE_W{1'b0}}, tbl};
    sel = kw - kw_t'(1);
    return ext[sel*SCORE_W +: SCORE_W];
  endfunction

endpackage

>>> hw/rtl/kscc_argmax.sv
// Registered-free argmax tree over the class scores, lowest index wins ties.
// Depends on kscc_pkg.
module kscc_argmax #(
  parameter int NUM_CLASSES = kscc_pkg::CLASSES_DEF
) (
  input  kscc_pkg::score_vec_t scores,
  output kscc_pkg::kw_t        best_idx,
  output kscc_pkg::score_t     best_val
);
  import kscc_pkg::*;

  score_t v1 [8];
  kw_t    i1 [8];
  score_t v2 [4];
  kw_t    i2 [4];
  score_t v3 [2];
  kw_t    i3 [2];

  // Unused classes read as zero and so never beat a lower index.
  always_comb begin
    for (int i = 0; i < NUM_SCORES; i++) begin
      v1[i] = (i < NUM_CLASSES) ? scores[i] : '0;
      i1[i] = kw_t'(i);
    end
    for (int p = 0; p < 4; p++) begin
      if (v1[2*p+1] > v1[2*p]) begin
        v2[p] = v1[2*p+1];
        i2[p] = i1[2*p+1];
      end else begin
        v2[p] = v1[2*p];
        i2[p] = i1[2*p];
      end
    end
    for (int p = 0; p < 2; p++) begin
      if (v2[2*p+1] > v2[2*p]) begin
        v3[p] = v2[2*p+1];
        i3[p] = i2[2*p+1];
      end else begin
        v3[p] = v2[2*p];
        i3[p] = i2[2*p];
      end
    end
    if (v3[1] > v3[0]) begin
      best_val = v3[1];
      best_idx = i3[1];
    end else begin
      best_val = v3[0];
      best_idx = i3[0];
    end
  end

endmodule

>>> hw/rtl/keyword_score_confirm_cooldown.sv
// Keyword decision: argmax, threshold, consecutive-hit confirm, report cooldown.
// Depends on kscc_pkg and kscc_argmax.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | in_score_0 .. in_score_7
//   out_    | output    | out_valid / out_ready| report_valid, keyword_index,
//           |           |                      | keyword_score, frame_number
//   cfg_    | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_ready is high. A transaction in the
// input register moves to the result register when that is free or read, and all
// state updates with it. While a result waits on out_ready the input register holds
// one more transaction at most; with both full, in_ready follows out_ready in the same cycle.
// Synchronous active-low reset clears the frame counter, the pending candidate,
// the per-keyword report frames and loads the table defaults.
module keyword_score_confirm_cooldown #(
  parameter int NUM_CLASSES = kscc_pkg::CLASSES_DEF,
  parameter int FRAME_WIDTH = kscc_pkg::FRAME_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  kscc_pkg::score_t           in_score_0,
  input  kscc_pkg::score_t           in_score_1,
  input  kscc_pkg::score_t           in_score_2,
  input  kscc_pkg::score_t           in_score_3,
  input  kscc_pkg::score_t           in_score_4,
  input  kscc_pkg::score_t           in_score_5,
  input  kscc_pkg::score_t           in_score_6,
  input  kscc_pkg::score_t           in_score_7,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_report_valid,
  output kscc_pkg::kw_t              out_keyword_index,
  output kscc_pkg::score_t           out_keyword_score,
  output logic [FRAME_WIDTH-1:0]     out_frame_number,
  input  logic                       cfg_we,
  input  kscc_pkg::cfg_idx_t         cfg_index,
  input  kscc_pkg::table_t           cfg_wdata
);
  import kscc_pkg::*;

  typedef logic [FRAME_WIDTH-1:0] frame_t;

  // configuration
  table_t threshold_r;
  table_t cooldown_r;
  score_t confirm_r;

  // input stage
  logic       s1_valid_r;
  score_vec_t s1_scores_r;

  // decision state
  frame_t frame_count_r;
  kw_t    pend_kw_r;
  score_t pend_hits_r;
  frame_t pend_frame_r;
  frame_t last_frame_r [NUM_SCORES];

  // result stage
  logic   out_valid_r;
  logic   rep_valid_r;
  kw_t    rep_kw_r;
  score_t rep_score_r;
  frame_t rep_frame_r;

  logic   adv;
  kw_t    best_idx;
  score_t best_val;
  frame_t frame_nxt;
  logic   hit;
  logic   cont;
  score_t hits_nxt;
  frame_t last;
  frame_t delta;
  logic   cooling;
  logic   report;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  kscc_argmax #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_argmax (
    .scores  (s1_scores_r),
    .best_idx(best_idx),
    .best_val(best_val)
  );

  always_comb begin
    frame_nxt = frame_count_r + frame_t'(1);
    hit       = (best_idx != '0) && (best_val >= tbl_byte(threshold_r, best_idx));
    // pend_frame + 1 == frame_nxt reduces to pend_frame == frame_count
    cont      = (pend_kw_r == best_idx) && (pend_frame_r == frame_count_r);
    if (!cont) begin
      hits_nxt = score_t'(1);
    end else if (pend_hits_r == HITS_MAX) begin
      hits_nxt = pend_hits_r;
    end else begin
      hits_nxt = pend_hits_r + score_t'(1);
    end
    last    = last_frame_r[best_idx];
    delta   = frame_nxt - last;
    cooling = (last != '0) &&
              (delta <= frame_t'(tbl_byte(cooldown_r, best_idx)));
    // confirm of zero acts as one since hits_nxt is at least one
    report  = hit && (hits_nxt >= confirm_r) && !cooling;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      cooldown_r  <= COOLDOWN_RST;
      confirm_r   <= CONFIRM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold_r <= cfg_wdata;
        REG_COOLDOWN:  cooldown_r  <= cfg_wdata;
        REG_CONFIRM:   confirm_r   <= cfg_wdata[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_scores_r <= {in_score_7, in_score_6, in_score_5, in_score_4,
                      in_score_3, in_score_2, in_score_1, in_score_0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      pend_kw_r     <= '0;
      pend_hits_r   <= '0;
      pend_frame_r  <= '0;
      for (int i = 0; i < NUM_SCORES; i++) begin
        last_frame_r[i] <= '0;
      end
    end else if (adv) begin
      frame_count_r <= frame_nxt;
      if (hit) begin
        pend_kw_r    <= best_idx;
        pend_hits_r  <= hits_nxt;
        pend_frame_r <= frame_nxt;
      end else begin
        pend_kw_r    <= '0;
        pend_hits_r  <= '0;
        pend_frame_r <= '0;
      end
      if (report) begin
        last_frame_r[best_idx] <= frame_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rep_valid_r <= report;
      rep_kw_r    <= report ? best_idx : '0;
      rep_score_r <= report ? best_val : '0;
      rep_frame_r <= frame_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_report_valid  = rep_valid_r;
  assign out_keyword_index = rep_kw_r;
  assign out_keyword_score = rep_score_r;
  assign out_frame_number  = rep_frame_r;

endmodule

>>> hw/rtl/kscc_checker.sv
// Port-level checks for keyword_score_confirm_cooldown, attached by bind.
// Depends on kscc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kscc_checker #(
  parameter int FRAME_WIDTH = kscc_pkg::FRAME_W_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_report_valid,
  input kscc_pkg::kw_t          out_keyword_index,
  input kscc_pkg::score_t       out_keyword_score,
  input logic [FRAME_WIDTH-1:0] out_frame_number
);
  import kscc_pkg::*;

  // a stalled result keeps its frame and report
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_frame_number) && $stable(out_report_valid), "result changed while stalled")

  // no report means zero index and score
  `CHK_IMPLY(a_quiet_zero, out_valid && !out_report_valid, (out_keyword_index == '0) && (out_keyword_score == '0), "non-report carries index or score")

  // a report names a keyword, never the unknown class, with a nonzero top score
  `CHK_IMPLY(a_report_kw, out_valid && out_report_valid, (out_keyword_index != '0) && (out_keyword_score != '0), "report with unknown class or zero score")

  // consecutive transactions carry consecutive frame numbers
  `CHK_NEXT(a_frame_step, out_valid && out_ready, !out_valid || (out_frame_number == $past(out_frame_number) + 1'b1), "frame number skipped")

endmodule

bind keyword_score_confirm_cooldown kscc_checker #(
  .FRAME_WIDTH(FRAME_WIDTH)
) u_kscc_checker (.*);

>>> tb/sv/keyword_score_confirm_cooldown_tb.sv
// Self-checking bench for keyword_score_confirm_cooldown: drives score frames and
// register writes and predicts each report in a scoreboard class.
// Depends on kscc_pkg and the keyword_score_confirm_cooldown RTL.
`timescale 1ns / 100ps

module keyword_score_confirm_cooldown_tb;
  import kscc_pkg::*;

  // index 3 decodes to no register; writes there must be dropped
  localparam cfg_idx_t REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic        hit;
    kw_t         kw;
    score_t      score;
    logic [31:0] frame;
  } kw_report_t;

  class keyword_decision_model;
    table_t      thresholds;
    table_t      cooldowns;
    score_t      confirm;
    logic [31:0] frame_count;
    kw_t         cand_kw;
    score_t      cand_hits;
    logic [31:0] cand_frame;
    logic [31:0] last_report[8];
    kw_report_t  expected_reports[$];
    int          errors;

    function new();
      thresholds  = THRESHOLD_RST;
      cooldowns   = COOLDOWN_RST;
      confirm     = CONFIRM_RST;
      frame_count = '0;
      cand_kw     = '0;
      cand_hits   = '0;
      cand_frame  = '0;
      foreach (last_report[i]) last_report[i] = '0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, table_t data);
      case (idx)
        REG_THRESHOLD: thresholds = data;
        REG_COOLDOWN:  cooldowns  = data;
        REG_CONFIRM:   confirm    = data[7:0];
        default: ;
      endcase
    endfunction

    // byte kw-1 of a packed per-keyword table
    function score_t byte_at(table_t t, kw_t kw);
      logic [63:0] ext;
      int          b;
      ext = {8'h00, t};
      b   = (int'(kw) + 7) % 8;
      return ext[b*8 +: 8];
    endfunction

    function score_t threshold_of(kw_t kw);
      return byte_at(thresholds, kw);
    endfunction

    function void predict_frame(score_vec_t s);
      kw_report_t  r;
      score_t      best_val;
      kw_t         best_kw;
      logic [31:0] delta;
      best_val    = '0;
      best_kw     = '0;
      frame_count = frame_count + 32'd1;
      r = '{hit: 1'b0, kw: '0, score: '0, frame: frame_count};
      for (int i = 0; i < NUM_SCORES; i++) begin
        if (s[i] > best_val) begin
          best_val = s[i];
          best_kw  = kw_t'(i);
        end
      end
      if (best_kw == 0 || best_val < byte_at(thresholds, best_kw)) begin
        cand_kw    = '0;
        cand_hits  = '0;
        cand_frame = '0;
      end else begin
        if (cand_kw == best_kw && cand_frame + 32'd1 == frame_count) begin
          if (cand_hits != HITS_MAX) cand_hits = cand_hits + 8'd1;
        end else begin
          cand_kw   = best_kw;
          cand_hits = 8'd1;
        end
        cand_frame = frame_count;
        delta      = frame_count - last_report[best_kw];
        if (cand_hits >= confirm &&
            !(last_report[best_kw] != 0 && delta <= 32'(byte_at(cooldowns, best_kw)))) begin
          last_report[best_kw] = frame_count;
          r.hit   = 1'b1;
          r.kw    = best_kw;
          r.score = best_val;
        end
      end
      expected_reports.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
    endtask

    task check_report(kw_report_t got);
      kw_report_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected result, frame_number %0d", got.frame));
        return;
      end
      want = expected_reports.pop_front();
      if (got.hit !== want.hit)
        report_mismatch($sformatf("frame %0d report_valid got %0b want %0b",
                                  want.frame, got.hit, want.hit));
      if (got.kw !== want.kw)
        report_mismatch($sformatf("frame %0d keyword_index got %0d want %0d",
                                  want.frame, got.kw, want.kw));
      if (got.score !== want.score)
        report_mismatch($sformatf("frame %0d keyword_score got %0d want %0d",
                                  want.frame, got.score, want.score));
      if (got.frame !== want.frame)
        report_mismatch($sformatf("frame_number got %0d want %0d", got.frame, want.frame));
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  score_t       in_score_0, in_score_1, in_score_2, in_score_3;
  score_t       in_score_4, in_score_5, in_score_6, in_score_7;
  logic         out_valid;
  logic         out_ready;
  logic         out_report_valid;
  kw_t          out_keyword_index;
  score_t       out_keyword_score;
  logic [31:0]  out_frame_number;
  logic         cfg_we;
  cfg_idx_t     cfg_index;
  table_t       cfg_wdata;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  keyword_decision_model decider = new();

  keyword_score_confirm_cooldown dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_score_0        (in_score_0),
    .in_score_1        (in_score_1),
    .in_score_2        (in_score_2),
    .in_score_3        (in_score_3),
    .in_score_4        (in_score_4),
    .in_score_5        (in_score_5),
    .in_score_6        (in_score_6),
    .in_score_7        (in_score_7),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_report_valid  (out_report_valid),
    .out_keyword_index (out_keyword_index),
    .out_keyword_score (out_keyword_score),
    .out_frame_number  (out_frame_number),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // keyword kw on top; above selects at/over threshold, else below it
  function automatic score_vec_t keyword_frame(kw_t kw, bit above);
    score_vec_t s;
    score_t     thr;
    score_t     top;
    thr = decider.threshold_of(kw);
    if (above || thr == 0) top = score_t'($urandom_range(thr, 255));
    else top = score_t'($urandom_range(0, thr - 1));
    for (int i = 0; i < NUM_SCORES; i++) begin
      if (i == kw) s[i] = top;
      else if (i < kw) s[i] = (top == 0) ? 8'd0 : score_t'($urandom_range(0, top - 1));
      else s[i] = score_t'($urandom_range(0, top));  // ties above kw lose to kw
    end
    return s;
  endfunction

  function automatic score_vec_t unknown_frame();
    score_vec_t s;
    s[0] = score_t'($urandom_range(0, 255));
    for (int i = 1; i < NUM_SCORES; i++) s[i] = score_t'($urandom_range(0, s[0]));
    return s;
  endfunction

  function automatic score_vec_t spot(int k, score_t v, score_t rest);
    score_vec_t s;
    s    = {NUM_SCORES{rest}};
    s[k] = v;
    return s;
  endfunction

  task automatic send_frame(score_vec_t s);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : int'($urandom_range(0, 19));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_score_7, in_score_6, in_score_5, in_score_4,
     in_score_3, in_score_2, in_score_1, in_score_0} <= s;
    do @(posedge clk); while (!in_ready);
    decider.predict_frame(s);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (decider.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // caller lowers cfg_we after the last write of a batch
  task automatic cfg_write(cfg_idx_t idx, table_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    decider.set_reg(idx, data);
  endtask

  task automatic set_config(table_t thr, table_t cool, table_t conf);
    drain_results();
    cfg_write(REG_THRESHOLD, thr);
    cfg_write(REG_COOLDOWN, cool);
    cfg_write(REG_CONFIRM, conf);
    cfg_we <= 1'b0;
  endtask

  function automatic table_t random_table();
    return table_t'({$urandom, $urandom});
  endfunction

  // mostly keyword runs, half of them long enough to confirm, mixed with broken runs and noise
  task automatic run_traffic(int n);
    int  sent;
    int  len;
    int  choice;
    kw_t kw;
    sent = 0;
    while (sent < n) begin
      choice = int'($urandom_range(0, 9));
      if (choice <= 5) begin
        kw  = kw_t'($urandom_range(1, 7));
        len = $urandom_range(0, 1) ? int'(decider.confirm) + int'($urandom_range(0, 24))
                                   : int'($urandom_range(1, 8));
        if (len < 1) len = 1;
        for (int k = 0; k < len; k++) send_frame(keyword_frame(kw, 1'b1));
        sent += len;
      end else begin
        case (choice)
          6:       send_frame(keyword_frame(kw_t'($urandom_range(1, 7)), 1'b0));
          7:       send_frame(unknown_frame());
          default: send_frame(score_vec_t'({$urandom, $urandom}));
        endcase
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      decider.check_report('{hit: out_report_valid, kw: out_keyword_index,
                             score: out_keyword_score, frame: out_frame_number});
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : int'($urandom_range(0, 19));
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #5000000;
    $display("keyword_score_confirm_cooldown regression: fail");
    $finish;
  end

  initial begin
    score_vec_t s;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    {in_score_7, in_score_6, in_score_5, in_score_4,
     in_score_3, in_score_2, in_score_1, in_score_0} <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_THRESHOLD;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    send_frame('0);                        // all zero selects unknown
    send_frame({NUM_SCORES{8'hFF}});       // full tie, class 0 wins
    send_frame(spot(7, 8'hFF, 8'h00));
    send_frame(spot(7, 8'hFF, 8'h00));     // confirmed
    send_frame(spot(7, 8'hFF, 8'h00));     // held off by cooldown
    send_frame(spot(7, 8'h61, 8'h00));     // just under threshold
    send_frame(spot(1, 8'h5F, 8'h00));
    send_frame(spot(1, 8'h60, 8'h00));     // exactly at threshold
    send_frame(spot(1, 8'h60, 8'h5F));
    s = spot(3, 8'h80, 8'h10);
    s[5] = 8'h80;                          // tie goes to lower keyword
    send_frame(s);
    send_frame(s);
    s = spot(2, 8'hFF, 8'h00);
    s[0] = 8'hFE;
    send_frame(s);
    send_frame(spot(4, 8'hFF, 8'h00));     // candidate switch restarts count
    send_frame(spot(4, 8'hFF, 8'h00));
    s = spot(6, 8'hFF, 8'h00);
    s[0] = 8'hFF;
    send_frame(s);
    send_frame(spot(6, 8'h62, 8'h00));
    send_frame(spot(6, 8'h62, 8'h61));
    send_frame(spot(5, 8'hC0, 8'hBF));
    send_frame(spot(5, 8'hC0, 8'hBF));
    send_frame(spot(1, 8'hFF, 8'h01));
    send_frame(spot(1, 8'hFF, 8'h01));
    run_traffic(300);

    set_config('0, '0, 56'd1);
    run_traffic(200);

    // upper bits of the confirm write must be ignored
    set_config({7{8'hFF}}, {7{8'hFF}}, {48'hA5A5_5A5A_C3C3, 8'hFF});
    run_traffic(500);

    // confirm of zero acts as one; stray write to the unused index
    set_config(random_table(), random_table(), 56'd0);
    @(posedge clk);
    cfg_write(REG_UNUSED, random_table());
    cfg_we <= 1'b0;
    run_traffic(300);

    set_config(random_table(), random_table(), table_t'($urandom_range(1, 6)));
    run_traffic(300);

    set_config(THRESHOLD_RST, COOLDOWN_RST, table_t'(CONFIRM_RST));
    run_traffic(150);

    drain_results();
    if (decider.errors == 0) begin
      $display("keyword_score_confirm_cooldown regression: pass");
    end else begin
      $display("keyword_score_confirm_cooldown regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/kscc_pkg.sv
hw/rtl/kscc_argmax.sv
hw/rtl/keyword_score_confirm_cooldown.sv
hw/rtl/kscc_checker.sv
tb/sv/keyword_score_confirm_cooldown_tb.sv
